[rtl/sacd_pkg.sv]
// Shared constants and types of the set-associative LRU cache directory.
// No dependencies; every module of the directory imports this package.
package sacd_pkg;

    localparam int WORD_BYTES  = 4;
    localparam int ADDR_W      = 32;
    localparam int ID_W        = 8;
    localparam int SET_OUT_W   = 6;
    localparam int WAY_OUT_W   = 2;
    localparam int VICTIM_W    = 27;
    localparam int CNT_W       = 32;
    localparam int PEN_W       = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [PEN_W-1:0] PEN_RESET = 16'd10;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } back_state_t;

endpackage

[rtl/set_assoc_lru_cache_directory.sv]
// Set-associative cache tag directory with true LRU replacement; top level.
// A request passes 2 front stages, the queue, the set read and the result register before its
// result is visible. The back end takes a new request only once the set row of the last one
// has been read and written back, and it waits while the result register holds a result not yet taken.
// Reset (synchronous, active low) clears counters, sets the miss penalty to 10, then sweeps
// every row of the set memory with s_ready low; configuration writes are taken during the sweep.
module set_assoc_lru_cache_directory #(
    parameter int BLOCK_WORDS = 8,
    parameter int NUM_SETS    = 64,
    parameter int WAYS        = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [sacd_pkg::ADDR_W-1:0]     s_address,
    input  logic [sacd_pkg::ID_W-1:0]       s_request_id,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [sacd_pkg::ID_W-1:0]       m_echo_id,
    output logic [sacd_pkg::SET_OUT_W-1:0]  m_set_number,
    output logic [sacd_pkg::WAY_OUT_W-1:0]  m_way_number,
    output logic                            m_evicted,
    output logic [sacd_pkg::VICTIM_W-1:0]   m_victim_line,
    output logic [sacd_pkg::CNT_W-1:0]      m_access_count,
    output logic [sacd_pkg::CNT_W-1:0]      m_hit_count,
    output logic [sacd_pkg::CNT_W-1:0]      m_miss_count,
    output logic [sacd_pkg::CNT_W-1:0]      m_stall_total,
    input  logic                            cfg_write_en,
    input  logic [sacd_pkg::PEN_W-1:0]      cfg_write_data
);
    import sacd_pkg::*;

    localparam int OFF_BITS  = $clog2(BLOCK_WORDS * WORD_BYTES);
    localparam int LINE_W    = ADDR_W - OFF_BITS;
    localparam int SET_FLOOR = $clog2(NUM_SETS + 1) - 1;
    localparam int SET_W     = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int TAG_W     = LINE_W - SET_FLOOR;
    localparam int QW        = ID_W + SET_W + TAG_W;

    logic              init_done;
    logic              f_valid;
    logic              f_ready;
    logic [ID_W-1:0]   f_id;
    logic [SET_W-1:0]  f_set;
    logic [TAG_W-1:0]  f_tag;
    logic              b_valid;
    logic              b_ready;
    logic [QW-1:0]     b_data;

    sacd_front #(
        .NUM_SETS (NUM_SETS),
        .OFF_BITS (OFF_BITS),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept_en    (init_done),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_address    (s_address),
        .s_request_id (s_request_id),
        .q_valid      (f_valid),
        .q_ready      (f_ready),
        .q_id         (f_id),
        .q_set        (f_set),
        .q_tag        (f_tag)
    );

    sacd_queue #(
        .WIDTH (QW)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   ({f_id, f_set, f_tag}),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    sacd_back #(
        .NUM_SETS (NUM_SETS),
        .WAYS     (WAYS),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W),
        .LINE_W   (LINE_W)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .init_done      (init_done),
        .q_valid        (b_valid),
        .q_ready        (b_ready),
        .q_id           (b_data[QW-1:SET_W+TAG_W]),
        .q_set          (b_data[SET_W+TAG_W-1:TAG_W]),
        .q_tag          (b_data[TAG_W-1:0]),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .m_echo_id      (m_echo_id),
        .m_set_number   (m_set_number),
        .m_way_number   (m_way_number),
        .m_evicted      (m_evicted),
        .m_victim_line  (m_victim_line),
        .m_access_count (m_access_count),
        .m_hit_count    (m_hit_count),
        .m_miss_count   (m_miss_count),
        .m_stall_total  (m_stall_total)
    );

    a_count_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_access_count == m_hit_count + m_miss_count)
        else $error("access count differs from hits plus misses");

    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> !m_evicted && m_victim_line == '0)
        else $error("hit reports an eviction");

    a_next_access: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid || m_access_count == $past(m_access_count) + 1'b1)
        else $error("access count skipped or repeated between results");

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !init_done |-> !m_valid && !b_ready)
        else $error("request served during set memory sweep");

endmodule

[rtl/sacd_front.sv]
// Request front end: accepts requests and splits the byte address into set and tag.
// Two-stage pipeline; the set/tag split uses a reciprocal multiply. Uses sacd_pkg.
module sacd_front #(
    parameter int NUM_SETS = 64,
    parameter int OFF_BITS = 5,
    parameter int SET_W    = 6,
    parameter int TAG_W    = 21
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept_en,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [sacd_pkg::ADDR_W-1:0]   s_address,
    input  logic [sacd_pkg::ID_W-1:0]     s_request_id,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [sacd_pkg::ID_W-1:0]     q_id,
    output logic [SET_W-1:0]              q_set,
    output logic [TAG_W-1:0]              q_tag
);
    import sacd_pkg::*;

    localparam int LINE_W   = ADDR_W - OFF_BITS;
    localparam int SET_CEIL = $clog2(NUM_SETS);
    localparam int SHIFT    = LINE_W + SET_CEIL;
    localparam int PROD_W   = 2 * LINE_W + 1;
    localparam int QUOT_W   = PROD_W - SHIFT;
    // ceil(2^SHIFT / NUM_SETS): exact quotient for every LINE_W-bit line address
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS);

    logic                v1_reg;
    logic [ID_W-1:0]     id1_reg;
    logic [LINE_W-1:0]   line1_reg;
    logic [PROD_W-1:0]   prod1_reg;
    logic                v2_reg;
    logic [ID_W-1:0]     id2_reg;
    logic [SET_W-1:0]    set2_reg;
    logic [TAG_W-1:0]    tag2_reg;

    logic [LINE_W-1:0]   line;
    logic [PROD_W-1:0]   prod_next;
    logic [QUOT_W-1:0]   quot;
    logic [LINE_W-1:0]   rem;
    logic                take;
    logic                push;
    logic                adv1;
    logic                adv2;

    assign line      = s_address[ADDR_W-1:OFF_BITS];
    assign prod_next = PROD_W'(line) * PROD_W'(RECIP);
    assign quot      = prod1_reg[PROD_W-1:SHIFT];
    assign rem       = line1_reg - LINE_W'(LINE_W'(quot) * LINE_W'(NUM_SETS));

    assign push    = v2_reg && q_ready;
    assign adv2    = !v2_reg || push;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1 && accept_en;
    assign take    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= take;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1 && take) begin
            id1_reg   <= s_request_id;
            line1_reg <= line;
            prod1_reg <= prod_next;
        end
        if (adv2 && v1_reg) begin
            id2_reg  <= id1_reg;
            set2_reg <= SET_W'(rem);
            tag2_reg <= TAG_W'(quot);
        end
    end

    assign q_valid = v2_reg;
    assign q_id    = id2_reg;
    assign q_set   = set2_reg;
    assign q_tag   = tag2_reg;

endmodule

[rtl/sacd_queue.sv]
// Short request queue between the front end and the directory back end.
// Register-based FIFO of QUEUE_DEPTH entries. Uses sacd_pkg.
module sacd_queue #(
    parameter int WIDTH = 35
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import sacd_pkg::*;

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]  data_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign in_ready  = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign out_data  = data_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

[rtl/sacd_back.sv]
// Directory back end: set memory with tags, valid bits and LRU ranks, hit/miss
// resolution, replacement, statistics counters and the result register. Uses sacd_pkg.
module sacd_back #(
    parameter int NUM_SETS = 64,
    parameter int WAYS     = 4,
    parameter int SET_W    = 6,
    parameter int TAG_W    = 21,
    parameter int LINE_W   = 27
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    output logic                            init_done,
    input  logic                            q_valid,
    output logic                            q_ready,
    input  logic [sacd_pkg::ID_W-1:0]       q_id,
    input  logic [SET_W-1:0]                q_set,
    input  logic [TAG_W-1:0]                q_tag,
    input  logic                            cfg_write_en,
    input  logic [sacd_pkg::PEN_W-1:0]      cfg_write_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_hit,
    output logic [sacd_pkg::ID_W-1:0]       m_echo_id,
    output logic [sacd_pkg::SET_OUT_W-1:0]  m_set_number,
    output logic [sacd_pkg::WAY_OUT_W-1:0]  m_way_number,
    output logic                            m_evicted,
    output logic [sacd_pkg::VICTIM_W-1:0]   m_victim_line,
    output logic [sacd_pkg::CNT_W-1:0]      m_access_count,
    output logic [sacd_pkg::CNT_W-1:0]      m_hit_count,
    output logic [sacd_pkg::CNT_W-1:0]      m_miss_count,
    output logic [sacd_pkg::CNT_W-1:0]      m_stall_total
);
    import sacd_pkg::*;

    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int RANK_W = WAY_W;
    localparam int RANK_LO = WAYS;
    localparam int TAG_LO  = WAYS + WAYS * RANK_W;
    localparam int ROW_W   = WAYS * (1 + RANK_W + TAG_W);

    // one row per set: {tags, ranks, valid bits}
    logic [ROW_W-1:0]   mem [NUM_SETS];
    logic [ROW_W-1:0]   rd_row_reg;

    back_state_t        state_reg, state_next;
    logic [SET_W-1:0]   clr_cnt_reg;
    logic [ID_W-1:0]    cur_id_reg;
    logic [SET_W-1:0]   cur_set_reg;
    logic [TAG_W-1:0]   cur_tag_reg;
    logic [PEN_W-1:0]   penalty_reg;
    logic [CNT_W-1:0]   acc_reg;
    logic [CNT_W-1:0]   hits_reg;
    logic [CNT_W-1:0]   miss_reg;
    logic [CNT_W-1:0]   stall_reg;

    logic                  m_valid_reg;
    logic                  m_hit_reg;
    logic [ID_W-1:0]       m_id_reg;
    logic [SET_OUT_W-1:0]  m_set_reg;
    logic [WAY_OUT_W-1:0]  m_way_reg;
    logic                  m_evicted_reg;
    logic [VICTIM_W-1:0]   m_victim_reg;

    logic                  mem_we;
    logic [SET_W-1:0]      mem_waddr;
    logic [ROW_W-1:0]      mem_wdata;
    logic                  mem_re;
    logic                  exec_fire;
    logic                  out_free;

    logic                  valid_arr [WAYS];
    logic [RANK_W-1:0]     rank_arr  [WAYS];
    logic [TAG_W-1:0]      tag_arr   [WAYS];
    logic                  hit_any;
    logic                  free_any;
    logic [WAY_W-1:0]      hit_way;
    logic [WAY_W-1:0]      free_way;
    logic [WAY_W-1:0]      lru_way;
    logic [WAY_W-1:0]      sel_way;
    logic [RANK_W-1:0]     old_rank;
    logic                  evict;
    logic [ROW_W-1:0]      upd_row;
    logic [ROW_W-1:0]      clear_row;
    logic [LINE_W-1:0]     victim_ln;
    logic [ADDR_W-1:0]     victim_ext;
    logic [ADDR_W-1:0]     set_ext;
    logic [ADDR_W-1:0]     way_ext;

    assign out_free  = !m_valid_reg || m_ready;
    assign init_done = state_reg != ST_CLEAR;

    // unpack the row read for the current request
    always_comb begin
        for (int w = 0; w < WAYS; w++) begin
            valid_arr[w] = rd_row_reg[w];
            rank_arr[w]  = rd_row_reg[RANK_LO + w * RANK_W +: RANK_W];
            tag_arr[w]   = rd_row_reg[TAG_LO + w * TAG_W +: TAG_W];
        end
    end

    // hit, first free way and LRU way
    always_comb begin
        hit_any  = 1'b0;
        free_any = 1'b0;
        hit_way  = '0;
        free_way = '0;
        lru_way  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (valid_arr[w] && tag_arr[w] == cur_tag_reg) begin
                hit_any = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (!valid_arr[w]) begin
                free_any = 1'b1;
                free_way = WAY_W'(w);
            end
        end
        // ranks form a permutation, so the oldest way holds the top rank
        for (int w = 0; w < WAYS; w++) begin
            if (rank_arr[w] == RANK_W'(WAYS - 1)) begin
                lru_way = WAY_W'(w);
            end
        end
    end

    assign sel_way  = hit_any ? hit_way : (free_any ? free_way : lru_way);
    assign evict    = !hit_any && !free_any;
    assign old_rank = rank_arr[sel_way];

    always_comb begin
        upd_row   = rd_row_reg;
        clear_row = '0;
        for (int w = 0; w < WAYS; w++) begin
            clear_row[RANK_LO + w * RANK_W +: RANK_W] = RANK_W'(w);
            if (WAY_W'(w) == sel_way) begin
                upd_row[RANK_LO + w * RANK_W +: RANK_W] = '0;
                if (!hit_any) begin
                    upd_row[w]                        = 1'b1;
                    upd_row[TAG_LO + w * TAG_W +: TAG_W] = cur_tag_reg;
                end
            end else if (rank_arr[w] < old_rank) begin
                upd_row[RANK_LO + w * RANK_W +: RANK_W] = rank_arr[w] + 1'b1;
            end
        end
    end

    assign victim_ln  = LINE_W'(LINE_W'(tag_arr[lru_way]) * LINE_W'(NUM_SETS))
                      + LINE_W'(cur_set_reg);
    assign victim_ext = evict ? ADDR_W'(victim_ln) : '0;
    assign set_ext    = ADDR_W'(cur_set_reg);
    assign way_ext    = ADDR_W'(sel_way);

    always_comb begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = cur_set_reg;
        mem_wdata  = upd_row;
        mem_re     = 1'b0;
        q_ready    = 1'b0;
        exec_fire  = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = clear_row;
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    mem_re     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    mem_we     = 1'b1;
                    exec_fire  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_row_reg <= mem[q_set];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            penalty_reg <= PEN_RESET;
            acc_reg     <= '0;
            hits_reg    <= '0;
            miss_reg    <= '0;
            stall_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_write_en) begin
                penalty_reg <= cfg_write_data;
            end
            if (exec_fire) begin
                acc_reg <= acc_reg + 1'b1;
                if (hit_any) begin
                    hits_reg <= hits_reg + 1'b1;
                end else begin
                    miss_reg  <= miss_reg + 1'b1;
                    stall_reg <= stall_reg + CNT_W'(penalty_reg);
                end
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_re) begin
            cur_id_reg  <= q_id;
            cur_set_reg <= q_set;
            cur_tag_reg <= q_tag;
        end
        if (exec_fire) begin
            m_hit_reg     <= hit_any;
            m_id_reg      <= cur_id_reg;
            m_set_reg     <= set_ext[SET_OUT_W-1:0];
            m_way_reg     <= way_ext[WAY_OUT_W-1:0];
            m_evicted_reg <= evict;
            m_victim_reg  <= victim_ext[VICTIM_W-1:0];
        end
    end

    // counters already hold the values that include the result being shown
    assign m_valid        = m_valid_reg;
    assign m_hit          = m_hit_reg;
    assign m_echo_id      = m_id_reg;
    assign m_set_number   = m_set_reg;
    assign m_way_number   = m_way_reg;
    assign m_evicted      = m_evicted_reg;
    assign m_victim_line  = m_victim_reg;
    assign m_access_count = acc_reg;
    assign m_hit_count    = hits_reg;
    assign m_miss_count   = miss_reg;
    assign m_stall_total  = stall_reg;

endmodule
